// ===== rtl/ymcrc_pkg.sv =====
// shared types, protocol byte codes and crc helper for the ymodem receiver
package ymcrc_pkg;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_CR  = 8'h0D;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [10:0] SMALL_BLOCK_LEN = 11'd128;
  localparam logic [10:0] LARGE_BLOCK_LEN = 11'd1024;
  localparam logic [10:0] BLOCK0_EXTRA    = 11'd4;
  localparam logic [7:0]  SEQ_PAIR_MASK   = 8'hFF;
  localparam logic [7:0]  FIRST_SEQ       = 8'd1;

  localparam logic MODE_START = 1'b0;
  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HUNT0,
    PH_BLK0,
    PH_HDR,
    PH_NUM1,
    PH_NUM2,
    PH_DATA,
    PH_CRCH,
    PH_CRCL
  } phase_t;

  typedef enum logic [1:0] {
    ST_NORMAL,
    ST_BAD_BLOCK,
    ST_CRC_ABORT,
    ST_END
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_C,
    OP_ACK_C,
    OP_ACK,
    OP_NAK,
    OP_END,
    OP_DATA
  } op_t;

  typedef struct packed {
    op_t         op;
    status_t     status;
    logic [7:0]  data;
    logic [31:0] offset;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/ymcrc_front.sv =====
// front part: protocol state machine, turns received bytes into commands for the back part
module ymcrc_front import ymcrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       mode,
  input  logic [7:0] rx_byte,
  output logic       push,
  output cmd_t       cmd
);

  phase_t      phase, phase_next;
  logic        large_block, large_block_next;
  logic [10:0] byte_count, byte_count_next;
  logic [7:0]  expected_sequence, expected_sequence_next;
  logic [7:0]  block_number_byte, block_number_byte_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_high, received_crc_high_next;
  logic [31:0] write_offset, write_offset_next;
  logic [31:0] cur_offset, cur_offset_next;

  logic [10:0] block_len;
  logic [10:0] count_inc;

  assign block_len = large_block ? LARGE_BLOCK_LEN : SMALL_BLOCK_LEN;
  assign count_inc = byte_count + 11'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      large_block       <= 1'b0;
      byte_count        <= '0;
      expected_sequence <= '0;
      block_number_byte <= '0;
      running_crc       <= '0;
      received_crc_high <= '0;
      write_offset      <= '0;
      cur_offset        <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      large_block       <= large_block_next;
      byte_count        <= byte_count_next;
      expected_sequence <= expected_sequence_next;
      block_number_byte <= block_number_byte_next;
      running_crc       <= running_crc_next;
      received_crc_high <= received_crc_high_next;
      write_offset      <= write_offset_next;
      cur_offset        <= cur_offset_next;
    end
  end

  always_comb begin
    phase_next             = phase;
    large_block_next       = large_block;
    byte_count_next        = byte_count;
    expected_sequence_next = expected_sequence;
    block_number_byte_next = block_number_byte;
    running_crc_next       = running_crc;
    received_crc_high_next = received_crc_high;
    write_offset_next      = write_offset;
    cur_offset_next        = cur_offset;
    cmd.op     = OP_NONE;
    cmd.status = ST_NORMAL;
    cmd.data   = rx_byte;
    cmd.offset = cur_offset;

    if (mode == MODE_START) begin
      large_block_next       = 1'b0;
      byte_count_next        = '0;
      expected_sequence_next = '0;
      block_number_byte_next = '0;
      running_crc_next       = '0;
      received_crc_high_next = '0;
      write_offset_next      = '0;
      cur_offset_next        = '0;
      phase_next             = PH_HUNT0;
      cmd.op                 = OP_START;
    end else begin
      unique case (phase)
        PH_HUNT0: begin
          if (rx_byte == B_SOH || rx_byte == B_STX) begin
            large_block_next = (rx_byte == B_STX);
            byte_count_next  = '0;
            phase_next       = PH_BLK0;
          end else begin
            cmd.op = OP_C;
          end
        end
        PH_BLK0: begin
          if (count_inc >= block_len + BLOCK0_EXTRA) begin
            byte_count_next        = '0;
            expected_sequence_next = FIRST_SEQ;
            phase_next             = PH_HDR;
            cmd.op                 = OP_ACK_C;
          end else begin
            byte_count_next = count_inc;
          end
        end
        PH_HDR: begin
          priority if (rx_byte == B_SOH || rx_byte == B_STX) begin
            large_block_next = (rx_byte == B_STX);
            phase_next       = PH_NUM1;
          end else if (rx_byte == B_EOT) begin
            cmd.op     = OP_END;
            cmd.status = ST_END;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_HDR;
          end
        end
        PH_NUM1: begin
          block_number_byte_next = rx_byte;
          phase_next             = PH_NUM2;
        end
        PH_NUM2: begin
          if ((block_number_byte ^ rx_byte) != SEQ_PAIR_MASK ||
              block_number_byte != expected_sequence) begin
            cmd.op     = OP_NAK;
            cmd.status = ST_BAD_BLOCK;
            phase_next = PH_HDR;
          end else begin
            byte_count_next  = '0;
            running_crc_next = '0;
            cur_offset_next  = write_offset;
            phase_next       = PH_DATA;
          end
        end
        PH_DATA: begin
          cmd.op           = OP_DATA;
          running_crc_next = crc16_byte(running_crc, rx_byte);
          byte_count_next  = count_inc;
          cur_offset_next  = cur_offset + 32'd1;
          if (count_inc >= block_len) begin
            phase_next = PH_CRCH;
          end
        end
        PH_CRCH: begin
          received_crc_high_next = rx_byte;
          phase_next             = PH_CRCL;
        end
        PH_CRCL: begin
          if ({received_crc_high, rx_byte} != running_crc) begin
            cmd.op     = OP_END;
            cmd.status = ST_CRC_ABORT;
            phase_next = PH_IDLE;
          end else begin
            write_offset_next      = write_offset + {21'd0, block_len};
            expected_sequence_next = expected_sequence + 8'd1;
            phase_next             = PH_HDR;
            cmd.op                 = OP_ACK;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  assign push = fire && (cmd.op != OP_NONE);

endmodule

// ===== rtl/ymcrc_queue.sv =====
// short command queue between front and back parts
module ymcrc_queue import ymcrc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  cmd_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full     = (count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ymcrc_back.sv =====
// back part: expands each command into result items and holds the output register
module ymcrc_back import ymcrc_pkg::*; #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  cmd_t        q_data,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  byte_value,
  output logic [31:0] write_address,
  output logic [1:0]  status,
  output logic        done_res,
  output logic        last
);

  logic [31:0] base_address;
  cmd_t        cur;
  logic        cur_valid;
  logic [2:0]  idx;
  logic [2:0]  last_idx;
  logic        is_last;
  logic        load;
  logic [7:0]  gen_byte;
  logic [31:0] addr_sum;
  logic [31:0] addr_mask;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      addr_mask[i] = (i < ADDR_WIDTH);
    end
  end

  assign addr_sum = base_address + cur.offset;

  always_comb begin
    unique case (cur.op)
      OP_START, OP_ACK_C: last_idx = 3'd1;
      OP_END:             last_idx = 3'd4;
      default:            last_idx = 3'd0;
    endcase
  end

  always_comb begin
    unique case (cur.op)
      OP_START: gen_byte = (idx == 3'd0) ? B_CR : B_C;
      OP_C:     gen_byte = B_C;
      OP_ACK_C: gen_byte = (idx == 3'd0) ? B_ACK : B_C;
      OP_ACK:   gen_byte = B_ACK;
      OP_NAK:   gen_byte = B_NAK;
      OP_END:   gen_byte = (idx == 3'd0) ? B_ACK : B_CAN;
      OP_DATA:  gen_byte = cur.data;
      default:  gen_byte = cur.data;
    endcase
  end

  assign is_last = (idx == last_idx);
  assign load    = cur_valid && (!out_valid || out_ready);
  assign q_pop   = !q_empty && (!cur_valid || (load && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg_write) begin
      base_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind          <= (cur.op == OP_DATA) ? KIND_WRITE : KIND_TX;
      byte_value    <= gen_byte;
      write_address <= (cur.op == OP_DATA) ? (addr_sum & addr_mask) : '0;
      status        <= cur.status;
      done_res      <= (cur.op == OP_END);
      last          <= is_last;
    end
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (load) begin
        if (is_last) begin
          cur_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/ymodem_crc_block_receiver_core.sv =====
// top level of the ymodem crc block receiver
//
//  channel | direction | signals                                          | handshake
//  in      | input     | mode, rx_byte                                    | in_valid / in_ready
//  out     | output    | kind, byte_value, write_address, status,         | out_valid / out_ready
//          |           | done_res, last                                   |
//  cfg     | input     | cfg_data (base_address)                          | cfg_write
//
// one item is accepted per cycle while the four-entry command queue has room
// each item yields zero to five result items, delivered one per cycle from the back part while out_ready is high
// the front state machine updates in the cycle an item is accepted
// out_ready low stalls the back part only; the front keeps accepting until the queue fills
// synchronous reset, no clearing pass; the block is ready the cycle after reset drops
module ymodem_crc_block_receiver_core import ymcrc_pkg::*; #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  byte_value,
  output logic [31:0] write_address,
  output logic [1:0]  status,
  output logic        done_res,
  output logic        last
);

  logic fire;
  logic push;
  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic pop;
  logic q_full;
  logic q_empty;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  ymcrc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .mode    (mode),
    .rx_byte (rx_byte),
    .push    (push),
    .cmd     (push_cmd)
  );

  ymcrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  ymcrc_back #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .q_data        (pop_cmd),
    .q_empty       (q_empty),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .byte_value    (byte_value),
    .write_address (write_address),
    .status        (status),
    .done_res      (done_res),
    .last          (last)
  );

endmodule
